FILE: rtl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int CP_W  = 21;
  localparam int RUN_W = 3;

  localparam logic [CP_W-1:0]  REPL_CP = 21'h00FFFD;

  // Lead and continuation byte prefixes after masking.
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;
  localparam logic [4:0] LEAD4_PFX = 5'b11110;
  localparam logic [1:0] CONT_PFX  = 2'b10;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last_in_run;
  } out_item_t;

  // One byte's results: (count - 1) replacements followed by the tail result.
  typedef struct packed {
    logic [RUN_W-1:0] count;
    logic [CP_W-1:0]  tail_cp;
    logic             tail_rep;
  } run_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: rtl/u8sd_front.sv
// Front end: classifies each byte, tracks the open sequence and emits a run descriptor.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_front import u8sd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     run_valid,
  output run_t     run
);

  logic [1:0]      exp_r, exp_nxt;
  logic [1:0]      acc_r, acc_nxt;
  logic [CP_W-1:0] part_r, part_nxt;

  always_comb begin
    logic [7:0]       b;
    logic             eot;
    logic             take;
    logic [RUN_W-1:0] nrep;
    logic [CP_W-1:0]  cont_val;
    logic [1:0]       acc_cap;

    b        = item.text_byte;
    eot      = item.end_of_text;
    take     = 1'b0;
    nrep     = '0;
    cont_val = {part_r[CP_W-7:0], b[5:0]};
    acc_cap  = (acc_r > 2'd2) ? 2'd2 : acc_r;

    exp_nxt      = exp_r;
    acc_nxt      = acc_r;
    part_nxt     = part_r;
    run.count    = '0;
    run.tail_cp  = REPL_CP;
    run.tail_rep = 1'b1;

    if (exp_r != 2'd0) begin
      if (b[7:6] == CONT_PFX) begin
        if (({1'b0, acc_r} + 3'd1) >= {1'b0, exp_r}) begin
          run.count    = 3'd1;
          run.tail_cp  = cont_val;
          run.tail_rep = 1'b0;
          exp_nxt      = '0;
          acc_nxt      = '0;
          part_nxt     = '0;
        end else if (eot) begin
          run.count = 3'd1;
          exp_nxt   = '0;
          acc_nxt   = '0;
          part_nxt  = '0;
        end else begin
          acc_nxt  = acc_r + 2'd1;
          part_nxt = cont_val;
        end
      end else begin
        // Broken sequence: one replacement for the lead and one per continuation,
        // then the same byte is rescanned as a lead.
        nrep     = 3'd1 + {1'b0, acc_cap};
        exp_nxt  = '0;
        acc_nxt  = '0;
        part_nxt = '0;
        take     = 1'b1;
      end
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (!b[7]) begin
        run.count    = nrep + 3'd1;
        run.tail_cp  = {13'd0, b};
        run.tail_rep = 1'b0;
      end else if (b[7:5] == LEAD2_PFX || b[7:4] == LEAD3_PFX || b[7:3] == LEAD4_PFX) begin
        if (eot) begin
          run.count = nrep + 3'd1;
        end else begin
          run.count = nrep;
          acc_nxt   = '0;
          if (b[7:5] == LEAD2_PFX) begin
            exp_nxt  = 2'd1;
            part_nxt = {16'd0, b[4:0]};
          end else if (b[7:4] == LEAD3_PFX) begin
            exp_nxt  = 2'd2;
            part_nxt = {17'd0, b[3:0]};
          end else begin
            exp_nxt  = 2'd3;
            part_nxt = {18'd0, b[2:0]};
          end
        end
      end else begin
        run.count = nrep + 3'd1;
      end
    end

    if (eot) begin
      exp_nxt  = '0;
      acc_nxt  = '0;
      part_nxt = '0;
    end

    run_valid = accept && (run.count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= '0;
      acc_r  <= '0;
      part_r <= '0;
    end else if (accept) begin
      exp_r  <= exp_nxt;
      acc_r  <= acc_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

FILE: rtl/u8sd_queue.sv
// Small FIFO of run descriptors between the front and back ends.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_queue import u8sd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  run_t      push_run,
  input  logic      pop,
  output run_t      head,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  run_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == FULL_CNT);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

endmodule

FILE: rtl/u8sd_back.sv
// Back end: expands run descriptors into result beats held in an output register.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_back import u8sd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  run_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  logic [RUN_W-1:0] rem_r, rem_nxt;
  logic [CP_W-1:0]  tail_cp_r;
  logic             tail_rep_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             load_out, emit;

  assign load_out = !out_valid_r || out_pop;
  assign emit     = load_out && (rem_r != '0);
  assign q_pop    = !q_empty && ((rem_r == '0) || (emit && rem_r == 3'd1));

  always_comb begin
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      rem_nxt       = rem_r - 3'd1;
      out_valid_nxt = 1'b1;
      if (rem_r == 3'd1) begin
        out_data_nxt = '{code_point: tail_cp_r, replaced: tail_rep_r, last_in_run: 1'b1};
      end else begin
        out_data_nxt = '{code_point: REPL_CP, replaced: 1'b1, last_in_run: 1'b0};
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      rem_nxt = head.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_pop) begin
      tail_cp_r  <= head.tail_cp;
      tail_rep_r <= head.tail_rep;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: front end, descriptor queue and back end.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
//
//   channel   direction  handshake            beat payload
//   in_       input      in_push / in_full    in_item_t  {text_byte, end_of_text}
//   out_      output     out_empty / out_pop  out_item_t {code_point, replaced, last_in_run}
//
// One byte beat is taken per cycle while the descriptor queue has room.
// The back end gives one result beat per cycle while the output is empty or popped,
// so a byte with k results takes k output beats; the queue absorbs those bursts.
// Results pass from the queue through the back end's run registers into the output register.
// Reset (rst_n low, synchronous) closes any open sequence and empties the queue
// and output register. A long output stall fills the queue and raises in_full.
`timescale 1ns / 1ps

module utf8_stream_decoder import u8sd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic      accept;
  logic      run_valid;
  run_t      front_run;
  run_t      q_head;
  logic      q_pop;
  q_status_t q_stat;

  // A byte is taken whenever the queue has a free slot. Bytes that produce no
  // result (a lead or a middle continuation) only update the sequence state.
  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  u8sd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .run_valid (run_valid),
    .run       (front_run)
  );

  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (run_valid),
    .push_run (front_run),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_stat)
  );

  // The back end walks each descriptor: replacement beats first, then the tail.
  u8sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_stat.empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  // A non-replacement result can only be the tail of its run.
  a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.replaced) |-> out_data.last_in_run)
    else $error("non-replacement result not marked last in run");

  // Within a run the next beat follows without a bubble.
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_data.last_in_run) |=> !out_empty)
    else $error("gap inside a run of results");

  // The front end never produces a descriptor into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid |-> !q_stat.full)
    else $error("descriptor pushed into full queue");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && q_stat.empty))
    else $error("results pending after reset");

endmodule
